// File: rtl/lfc_pkg.sv
package lfc_pkg;

  localparam int LEVEL_W    = 5;
  localparam int DIM_IDX_W  = 3;
  localparam int COORD_W    = 16;
  localparam int CORR_W     = 17;
  localparam int DIMS_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // A squared difference fits in 32 bits; fifteen of them fit in 36.
  localparam int SQ_W  = 32;
  localparam int SUM_W = 36;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LATENT_DIMS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DIAG    = 1'd1;

  localparam logic [DIMS_W-1:0] LATENT_DIMS_RST = 4'd1;
  localparam logic [CORR_W-1:0] OFF_DIAG_RST    = 17'd65535;
  localparam logic [CORR_W-1:0] ONE_Q16         = 17'd65536;

  // log2(e) in Q1.30.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  // round(65536 * 2^(-i/16)) for i = 0..16.
  function automatic logic [CORR_W-1:0] pow2_neg(input logic [4:0] idx);
    logic [CORR_W-1:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic              start;
    logic              rd_en;
    logic [DIMS_W-1:0] rd_dim;
    logic              mul_lo;
    logic              mul_hi;
    logic              calc_t;
    logic              calc_m;
    logic              calc_res;
    logic              out_load;
  } lfc_cmd_t;

  typedef struct packed {
    logic              is_write;
    logic              is_short;
    logic [DIMS_W-1:0] dims_eff;
    logic              pipe_busy;
    logic              out_free;
  } lfc_stat_t;

endpackage

// File: rtl/lfc_in_if.sv
interface lfc_in_if;
  import lfc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [LEVEL_W-1:0]          level_a;
  logic [LEVEL_W-1:0]          level_b;
  logic [DIM_IDX_W-1:0]        coord_index;
  logic signed [COORD_W-1:0]   coord_value;
  logic                        same_row;

  modport source (
    output valid, action, level_a, level_b, coord_index, coord_value, same_row,
    input  ready
  );
  modport sink (
    input  valid, action, level_a, level_b, coord_index, coord_value, same_row,
    output ready
  );
endinterface

// File: rtl/lfc_out_if.sv
interface lfc_out_if;
  import lfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CORR_W-1:0] correlation;

  modport source (output valid, correlation, input ready);
  modport sink (input valid, correlation, output ready);
endinterface

// File: rtl/lfc_ctrl.sv
module lfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfc_pkg::lfc_stat_t stat,
  output lfc_pkg::lfc_cmd_t  cmd
);
  import lfc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WALK  = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_MLO   = 4'd3;
  localparam logic [3:0] S_MHI   = 4'd4;
  localparam logic [3:0] S_TCALC = 4'd5;
  localparam logic [3:0] S_MCALC = 4'd6;
  localparam logic [3:0] S_RES   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [DIMS_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    cmd.rd_dim = cnt_r;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          if (stat.is_write) begin
            state_nxt = S_IDLE;
          end else if (stat.is_short) begin
            state_nxt = S_FIN;
          end else if (stat.dims_eff == '0) begin
            state_nxt = S_MLO;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == stat.dims_eff - 4'd1) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_DRAIN: begin
        // Wait until the last squared difference has been added.
        if (!stat.pipe_busy) begin
          state_nxt = S_MLO;
        end
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_TCALC;
      end
      S_TCALC: begin
        cmd.calc_t = 1'b1;
        state_nxt  = S_MCALC;
      end
      S_MCALC: begin
        cmd.calc_m = 1'b1;
        state_nxt  = S_RES;
      end
      S_RES: begin
        cmd.calc_res = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lfc_dp.sv
module lfc_dp #(
  parameter int MAX_LEVELS = 16,
  parameter int MAX_DIMS   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [lfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lfc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_action,
  input  logic [lfc_pkg::LEVEL_W-1:0]          in_level_a,
  input  logic [lfc_pkg::LEVEL_W-1:0]          in_level_b,
  input  logic [lfc_pkg::DIM_IDX_W-1:0]        in_coord_index,
  input  logic signed [lfc_pkg::COORD_W-1:0]   in_coord_value,
  input  logic                                 in_same_row,
  input  lfc_pkg::lfc_cmd_t                    cmd,
  output lfc_pkg::lfc_stat_t                   stat,
  output logic                                 out_valid,
  output logic [lfc_pkg::CORR_W-1:0]           out_correlation,
  input  logic                                 out_ready
);
  import lfc_pkg::*;

  localparam int DEPTH  = MAX_LEVELS * MAX_DIMS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ADDR_W = 16;

  logic [DIMS_W-1:0]         latent_dims_r;
  logic [CORR_W-1:0]         off_diag_r;

  logic signed [COORD_W-1:0] mem [DEPTH];

  logic [LEVEL_W-1:0]        lev_a_m1_r, lev_b_m1_r;
  logic                      va_r, vb_r;
  logic signed [COORD_W-1:0] rd_a_r, rd_b_r;
  logic                      rd_v_r;
  logic [SQ_W-1:0]           sq_r;
  logic                      sq_v_r;
  logic [SUM_W-1:0]          sum_r;
  logic [35:0]               p_lo_r;
  logic [34:0]               p_hi_r;
  logic                      flush_r;
  logic [21:0]               t_r;
  logic [CORR_W-1:0]         m_r;
  logic [5:0]                n_r;
  logic [CORR_W-1:0]         res_r;
  logic                      out_valid_r;
  logic [CORR_W-1:0]         out_corr_r;

  logic                      lev_a_ok, lev_b_ok, wr_ok;
  logic [LEVEL_W-1:0]        lev_a_m1, lev_b_m1;
  logic [ADDR_W-1:0]         wr_full, rd_full_a, rd_full_b;
  logic [AW-1:0]             wr_addr, rd_addr_a, rd_addr_b;
  logic signed [COORD_W-1:0] a_val, b_val;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          abs_d;
  logic [33:0]               sq_full;
  logic [27:0]               s16;
  logic [15:0]               mul_b;
  logic [35:0]               mul_p;
  logic [51:0]               t_full;
  logic [15:0]               frac;
  logic [CORR_W-1:0]         tab_hi, tab_lo, tab_dl;
  logic [28:0]               interp;
  logic [17:0]               rnd;
  logic [CORR_W-1:0]         res_calc;
  logic                      is_query;

  // Decode of the incoming beat.
  assign is_query = (in_action == ACT_QUERY);
  assign lev_a_ok = (in_level_a != '0) && (9'(in_level_a) <= 9'(MAX_LEVELS));
  assign lev_b_ok = (in_level_b != '0) && (9'(in_level_b) <= 9'(MAX_LEVELS));
  assign wr_ok    = lev_a_ok && (6'(in_coord_index) < 6'(MAX_DIMS));
  assign lev_a_m1 = in_level_a - 5'd1;
  assign lev_b_m1 = in_level_b - 5'd1;

  assign wr_full   = ADDR_W'(lev_a_m1) * ADDR_W'(MAX_DIMS) + ADDR_W'(in_coord_index);
  assign rd_full_a = ADDR_W'(lev_a_m1_r) * ADDR_W'(MAX_DIMS) + ADDR_W'(cmd.rd_dim);
  assign rd_full_b = ADDR_W'(lev_b_m1_r) * ADDR_W'(MAX_DIMS) + ADDR_W'(cmd.rd_dim);
  assign wr_addr   = wr_full[AW-1:0];
  assign rd_addr_a = rd_full_a[AW-1:0];
  assign rd_addr_b = rd_full_b[AW-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latent_dims_r <= LATENT_DIMS_RST;
      off_diag_r    <= OFF_DIAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LATENT_DIMS: latent_dims_r <= cfg_data[DIMS_W-1:0];
        REG_OFF_DIAG:    off_diag_r    <= cfg_data[CORR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Coordinate table: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.start && !is_query && wr_ok) begin
      mem[wr_addr] <= in_coord_value;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  // A level outside the table reads as all-zero coordinates.
  assign a_val   = va_r ? rd_a_r : '0;
  assign b_val   = vb_r ? rd_b_r : '0;
  assign diff    = {a_val[COORD_W-1], a_val} - {b_val[COORD_W-1], b_val};
  assign abs_d   = diff[COORD_W] ? 17'(-diff) : 17'(diff);
  assign sq_full = 34'(abs_d) * 34'(abs_d);

  // Exponent: T = S16 * log2(e), built from two partial products.
  assign s16    = sum_r[SUM_W-1:8];
  assign mul_b  = cmd.mul_hi ? {1'b0, LOG2E_Q30[30:16]} : LOG2E_Q30[15:0];
  assign mul_p  = 36'(s16[19:0]) * 36'(mul_b);
  assign t_full = (52'(p_hi_r) << 16) + 52'(p_lo_r) + 52'd536870912;

  // Table interpolation of 2^-F.
  assign frac   = t_r[15:0];
  assign tab_hi = pow2_neg({1'b0, frac[15:12]});
  assign tab_lo = pow2_neg({1'b0, frac[15:12]} + 5'd1);
  assign tab_dl = tab_hi - tab_lo;
  assign interp = 29'(tab_dl) * 29'(frac[11:0]) + 29'd2048;

  assign rnd = (18'(m_r) + (18'd1 << (n_r - 6'd1))) >> n_r;

  always_comb begin
    if (flush_r || (n_r > 6'd16)) begin
      res_calc = '0;
    end else if (n_r == 6'd0) begin
      res_calc = m_r;
    end else begin
      res_calc = rnd[CORR_W-1:0];
    end
  end

  // Control flags of the walk pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      sq_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
      sq_v_r <= rd_v_r;
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lev_a_m1_r <= lev_a_m1;
      lev_b_m1_r <= lev_b_m1;
      va_r       <= lev_a_ok;
      vb_r       <= lev_b_ok;
      sum_r      <= '0;
      if (in_same_row) begin
        res_r <= ONE_Q16;
      end else begin
        res_r <= (off_diag_r > ONE_Q16) ? ONE_Q16 : off_diag_r;
      end
    end else if (sq_v_r) begin
      sum_r <= sum_r + SUM_W'(sq_r);
    end
    if (rd_v_r) begin
      sq_r <= sq_full[SQ_W-1:0];
    end
    if (cmd.mul_lo) begin
      p_lo_r  <= mul_p;
      flush_r <= |s16[27:20];
    end
    if (cmd.mul_hi) begin
      p_hi_r <= mul_p[34:0];
    end
    if (cmd.calc_t) begin
      t_r <= t_full[51:30];
    end
    if (cmd.calc_m) begin
      m_r <= tab_hi - CORR_W'(interp >> 12);
      n_r <= t_r[21:16];
    end
    if (cmd.calc_res) begin
      res_r <= res_calc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_corr_r <= res_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_correlation = out_corr_r;

  assign stat.is_write  = !is_query;
  assign stat.is_short  = in_same_row || (in_level_a == in_level_b);
  assign stat.dims_eff  = (6'(latent_dims_r) > 6'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS)
                                                            : latent_dims_r;
  assign stat.pipe_busy = rd_v_r || sq_v_r;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

// File: rtl/latent_factor_correlation.sv
// Latent-factor correlation unit. A write beat stores one signed Q4.12
// coordinate of one level; a query beat returns one unsigned Q1.16
// correlation: 1.0 for a diagonal element, the off-diagonal register for
// equal levels, and otherwise exp(-sum of squared coordinate differences)
// over the active dimensions (latent_dims, clamped to MAX_DIMS). A write
// is done once its beat is accepted; a diagonal or equal-level query goes
// from accepting the beat straight to handing on its result. Any other
// query accepts the beat, walks the coordinate table through its two read
// ports at one dimension per cycle, drains the square-and-add pipeline,
// runs five register stages for the exponential, the first two of which
// share one multiplier for log2(e), and hands the result to the output
// register; with latent_dims zero it skips the walk and the drain. Handing
// on the result waits for as long as the output register holds a result
// that has not been taken. Items are handled one at a time; a finished
// result waits in the output register while the next beat is accepted. A
// coordinate must be written before any query reads it.
module latent_factor_correlation #(
  parameter int MAX_LEVELS = 16,
  parameter int MAX_DIMS   = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data,
  lfc_in_if.sink                         in_if,
  lfc_out_if.source                      out_if
);
  import lfc_pkg::*;

  lfc_cmd_t  cmd;
  lfc_stat_t stat;
  logic      in_rdy;

  assign in_if.ready = in_rdy;

  lfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_rdy),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfc_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_action       (in_if.action),
    .in_level_a      (in_if.level_a),
    .in_level_b      (in_if.level_b),
    .in_coord_index  (in_if.coord_index),
    .in_coord_value  (in_if.coord_value),
    .in_same_row     (in_if.same_row),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_if.valid),
    .out_correlation (out_if.correlation),
    .out_ready       (out_if.ready)
  );

endmodule
